// ----- rtl/s16p_pkg.sv -----
// Shared constants, layout tables and helper functions for the Simple16 packer.
package s16p_pkg;

  localparam int VALUE_W     = 32;
  localparam int BUF_DEPTH   = 28;
  localparam int CNT_W       = 5;
  localparam int NUM_LAYOUTS = 15;
  localparam int SEL_W       = 4;
  localparam int PAYLOAD_W   = 28;
  localparam int SW_W        = 4;
  localparam int NUM_GRPS    = 3;
  localparam int POS_W       = 6;

  localparam logic [SEL_W-1:0] FALLBACK_SEL = 4'd15;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [SW_W-1:0]  slot_w_t;

  // Group counts and widths per selector
  localparam cnt_t GRP_CNT [NUM_LAYOUTS][NUM_GRPS] = '{
    '{5'd28, 5'd0,  5'd0}, '{5'd7,  5'd14, 5'd0}, '{5'd7,  5'd7, 5'd7},
    '{5'd14, 5'd7,  5'd0}, '{5'd14, 5'd0,  5'd0}, '{5'd1,  5'd8, 5'd0},
    '{5'd1,  5'd4,  5'd3}, '{5'd7,  5'd0,  5'd0}, '{5'd4,  5'd2, 5'd0},
    '{5'd2,  5'd4,  5'd0}, '{5'd3,  5'd2,  5'd0}, '{5'd2,  5'd3, 5'd0},
    '{5'd4,  5'd0,  5'd0}, '{5'd1,  5'd2,  5'd0}, '{5'd2,  5'd0, 5'd0}
  };

  localparam slot_w_t GRP_W [NUM_LAYOUTS][NUM_GRPS] = '{
    '{4'd1,  4'd0, 4'd0}, '{4'd2,  4'd1, 4'd0}, '{4'd1, 4'd2, 4'd1},
    '{4'd1,  4'd2, 4'd0}, '{4'd2,  4'd0, 4'd0}, '{4'd4, 4'd3, 4'd0},
    '{4'd3,  4'd4, 4'd3}, '{4'd4,  4'd0, 4'd0}, '{4'd5, 4'd4, 4'd0},
    '{4'd4,  4'd5, 4'd0}, '{4'd6,  4'd5, 4'd0}, '{4'd5, 4'd6, 4'd0},
    '{4'd7,  4'd0, 4'd0}, '{4'd10, 4'd9, 4'd0}, '{4'd14, 4'd0, 4'd0}
  };

  // Every amount a pack can remove while values remain behind
  localparam int NUM_SHIFTS = 11;
  localparam cnt_t SHIFTS [NUM_SHIFTS] = '{
    5'd21, 5'd14, 5'd9, 5'd8, 5'd7, 5'd6, 5'd5, 5'd4, 5'd3, 5'd2, 5'd1
  };

  // Slot width at a buffer position for a layout; zero past its capacity
  function automatic slot_w_t slot_width(input logic [SEL_W-1:0] sel,
                                         input cnt_t pos);
    cnt_t    p;
    slot_w_t w;
    logic    hit;
    p   = pos;
    w   = '0;
    hit = 1'b0;
    for (int g = 0; g < NUM_GRPS; g++) begin
      if (!hit) begin
        if (p < GRP_CNT[sel][g]) begin
          w   = GRP_W[sel][g];
          hit = 1'b1;
        end else begin
          p = p - GRP_CNT[sel][g];
        end
      end
    end
    return w;
  endfunction

  function automatic cnt_t capacity(input logic [SEL_W-1:0] sel);
    return GRP_CNT[sel][0] + GRP_CNT[sel][1] + GRP_CNT[sel][2];
  endfunction

endpackage

// ----- rtl/s16p_in_if.sv -----
// Input channel: one integer request with its end-of-array mark.
interface s16p_in_if import s16p_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic               last;

  modport source (output valid, value, last, input ready);
  modport sink   (input valid, value, last, output ready);
endinterface

// ----- rtl/s16p_out_if.sv -----
// Output channel: one packed word request with its flags.
interface s16p_out_if import s16p_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] packed_word;
  logic               last_word;
  logic               overflow;

  modport source (output valid, packed_word, last_word, overflow, input ready);
  modport sink   (input valid, packed_word, last_word, overflow, output ready);
endinterface

// ----- rtl/simple16_integer_packer_core.sv -----
// Simple16 packer: 28-entry value buffer, one-pass layout choice, output register.
// Throughput: one integer per cycle while no drain runs and the output is not held off.
// A word is packed once the buffer holds 28 values and the output register is free; the
// integer that follows is taken in that cycle. After a last request the single pack unit
// emits one word per cycle while the output accepts until the buffer is empty, input held
// off meanwhile. Words are registered. Reset clears count, drain flag and output valid.
module simple16_integer_packer_core import s16p_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  s16p_in_if.sink     din,
  s16p_out_if.source  dout
);

  logic [VALUE_W-1:0] vals [BUF_DEPTH];
  cnt_t               count;
  logic               draining;
  logic               out_valid;
  logic [VALUE_W-1:0] out_word;
  logic               out_last;
  logic               out_ovf;

  logic [VALUE_W-1:0] vm [BUF_DEPTH];
  logic [VALUE_W-1:0] sh [BUF_DEPTH];
  logic [VALUE_W-1:0] cand [NUM_LAYOUTS];
  logic [NUM_LAYOUTS-1:0] fit;
  logic [BUF_DEPTH-1:0]   live;
  logic [VALUE_W-1:0] word;
  logic               found;
  cnt_t               cap;
  cnt_t               used;
  cnt_t               cnt_after;
  logic               ovf;
  logic               do_pack;
  logic               pack_fire;
  logic               in_ready;
  logic               in_fire;

  // Layout fit checks and candidate words
  always_comb begin
    logic [POS_W-1:0] p;
    slot_w_t          w;
    logic [VALUE_W-1:0] acc;
    for (int i = 0; i < BUF_DEPTH; i++) begin
      live[i] = cnt_t'(i) < count;
      vm[i]   = live[i] ? vals[i] : '0;
    end
    for (int s = 0; s < NUM_LAYOUTS; s++) begin
      fit[s] = 1'b1;
      acc    = {SEL_W'(s), {PAYLOAD_W{1'b0}}};
      p      = POS_W'(PAYLOAD_W);
      for (int i = 0; i < BUF_DEPTH; i++) begin
        w = slot_width(SEL_W'(s), cnt_t'(i));
        if (w != '0) begin
          if (live[i] && ((vals[i] >> w) != '0)) fit[s] = 1'b0;
          p   = p - POS_W'(w);
          acc = acc | (vm[i] << p);
        end
      end
      cand[s] = acc;
    end
  end

  // First fitting layout wins; otherwise one value in 28 bits
  always_comb begin
    found = 1'b0;
    word  = {FALLBACK_SEL, vals[0][PAYLOAD_W-1:0]};
    cap   = cnt_t'(1);
    for (int s = 0; s < NUM_LAYOUTS; s++) begin
      if (!found && fit[s]) begin
        found = 1'b1;
        word  = cand[s];
        cap   = capacity(SEL_W'(s));
      end
    end
    used = (found && count < cap) ? count : cap;
    ovf  = !found && (vals[0][VALUE_W-1:PAYLOAD_W] != '0);
  end

  // Drop the packed values from the front
  always_comb begin
    for (int j = 0; j < BUF_DEPTH; j++) begin
      sh[j] = vals[j];
      for (int k = 0; k < NUM_SHIFTS; k++) begin
        if ((j + int'(SHIFTS[k]) < BUF_DEPTH) && used == SHIFTS[k])
          sh[j] = vals[(j + int'(SHIFTS[k])) % BUF_DEPTH];
      end
    end
  end

  assign do_pack   = (count == cnt_t'(BUF_DEPTH)) || (draining && count != '0);
  assign pack_fire = do_pack && (!out_valid || dout.ready);
  assign cnt_after = pack_fire ? count - used : count;
  assign in_ready  = !draining && (count != cnt_t'(BUF_DEPTH) || pack_fire);
  assign in_fire   = din.valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      draining  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      count <= cnt_after + cnt_t'(in_fire);
      if (in_fire && din.last) begin
        draining <= 1'b1;
      end else if (pack_fire && cnt_after == '0) begin
        draining <= 1'b0;
      end
      if (pack_fire) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < BUF_DEPTH; j++) begin
      if (in_fire && cnt_after == cnt_t'(j)) begin
        vals[j] <= din.value;
      end else if (pack_fire) begin
        vals[j] <= sh[j];
      end
    end
    if (pack_fire) begin
      out_word <= word;
      out_last <= draining && cnt_after == '0;
      out_ovf  <= ovf;
    end
  end

  assign din.ready        = in_ready;
  assign dout.valid       = out_valid;
  assign dout.packed_word = out_word;
  assign dout.last_word   = out_last;
  assign dout.overflow    = out_ovf;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= cnt_t'(BUF_DEPTH))
    else $error("buffer count above depth");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    draining |-> count != '0)
    else $error("drain active on empty buffer");

  a_drain_blocks_input: assert property (@(posedge clk) disable iff (rst)
    draining |-> !din.ready)
    else $error("input taken during drain");

  a_full_needs_pack: assert property (@(posedge clk) disable iff (rst)
    (count == cnt_t'(BUF_DEPTH) && !pack_fire) |-> !din.ready)
    else $error("input taken into full buffer");

  a_drain_ends: assert property (@(posedge clk) disable iff (rst)
    (pack_fire && draining && cnt_after == '0) |=> (!draining && count == '0))
    else $error("drain did not end on final word");

endmodule

// ----- sim/s16p_checker.sv -----
// Checker: follows both channels, packs its own copy of the integer stream and compares words.
module s16p_checker import s16p_pkg::*; (
  input  logic clk,
  input  logic rst,
  s16p_in_if   din,
  s16p_out_if  dout,
  output int   mismatches,
  output int   words_due
);

  typedef struct packed {
    logic [VALUE_W-1:0] word;
    logic               last_word;
    logic               overflow;
  } word_t;

  // Simple16 layouts: group counts and slot widths per selector
  localparam int SLOT_COUNT [NUM_LAYOUTS][3] = '{
    '{28, 0, 0}, '{7, 14, 0}, '{7, 7, 7}, '{14, 7, 0}, '{14, 0, 0},
    '{1, 8, 0},  '{1, 4, 3},  '{7, 0, 0}, '{4, 2, 0},  '{2, 4, 0},
    '{3, 2, 0},  '{2, 3, 0},  '{4, 0, 0}, '{1, 2, 0},  '{2, 0, 0}
  };
  localparam int SLOT_BITS [NUM_LAYOUTS][3] = '{
    '{1, 0, 0},  '{2, 1, 0},  '{1, 2, 1}, '{1, 2, 0},  '{2, 0, 0},
    '{4, 3, 0},  '{3, 4, 3},  '{4, 0, 0}, '{5, 4, 0},  '{4, 5, 0},
    '{6, 5, 0},  '{5, 6, 0},  '{7, 0, 0}, '{10, 9, 0}, '{14, 0, 0}
  };

  logic [VALUE_W-1:0] held [BUF_DEPTH];
  int                 held_cnt;
  word_t              due_words [$];

  // zero once the position is past the layout's capacity
  function automatic int slot_bits(int sel, int pos);
    int p;
    int w;
    p = pos;
    w = 0;
    for (int g = 0; g < 3; g++) begin
      if (w == 0) begin
        if (p < SLOT_COUNT[sel][g]) w = SLOT_BITS[sel][g];
        else p -= SLOT_COUNT[sel][g];
      end
    end
    return w;
  endfunction

  // Packs one word from the front of the held values and drops what it took
  function automatic word_t pack_front_word();
    word_t              r;
    logic [VALUE_W-1:0] acc;
    int                 used;
    int                 pos;
    int                 w;
    bit                 fits;
    bit                 found;
    found = 1'b0;
    used  = 0;
    acc   = '0;
    for (int sel = 0; sel < NUM_LAYOUTS && !found; sel++) begin
      fits = 1'b1;
      used = 0;
      for (int i = 0; i < held_cnt; i++) begin
        w = slot_bits(sel, i);
        if (w == 0) break;
        if ((held[i] >> w) != 0) begin
          fits = 1'b0;
          break;
        end
        used++;
      end
      if (fits) begin
        acc = 32'(sel) << PAYLOAD_W;
        pos = PAYLOAD_W;
        for (int i = 0; i < used; i++) begin
          pos -= slot_bits(sel, i);
          acc |= held[i] << pos;
        end
        found = 1'b1;
      end
    end
    r.overflow = 1'b0;
    if (!found) begin
      acc        = {FALLBACK_SEL, held[0][PAYLOAD_W-1:0]};
      r.overflow = |held[0][VALUE_W-1:PAYLOAD_W];
      used       = 1;
    end
    for (int i = 0; i + used < held_cnt; i++) held[i] = held[i + used];
    held_cnt    -= used;
    r.word      = acc;
    r.last_word = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    word_t got;
    word_t want;
    if (rst) begin
      held_cnt = 0;
      due_words.delete();
      mismatches = 0;
    end else begin
      // input side first: a word can never leave in the cycle its integer arrives
      if (din.valid && din.ready) begin
        if (held_cnt < BUF_DEPTH) begin
          held[held_cnt] = din.value;
          held_cnt++;
        end
        if (din.last) begin
          while (held_cnt > 0) begin
            want           = pack_front_word();
            want.last_word = (held_cnt == 0);
            due_words.push_back(want);
          end
        end else if (held_cnt >= BUF_DEPTH) begin
          due_words.push_back(pack_front_word());
        end
      end
      if (dout.valid && dout.ready) begin
        got.word      = dout.packed_word;
        got.last_word = dout.last_word;
        got.overflow  = dout.overflow;
        if (due_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] unexpected word %h last %b ovf %b", $realtime,
                     got.word, got.last_word, got.overflow);
        end else begin
          want = due_words.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("[%0t] word mismatch: expected %h last %b ovf %b, got %h last %b ovf %b",
                       $realtime, want.word, want.last_word, want.overflow,
                       got.word, got.last_word, got.overflow);
          end
        end
      end
    end
    words_due = due_words.size();
  end

endmodule

// ----- sim/tb_simple16_integer_packer_core.sv -----
// Testbench top: clock, reset, integer stream and output back-pressure for the Simple16 packer.
module tb_simple16_integer_packer_core import s16p_pkg::*; ();

  localparam int STUCK_LIMIT = 2000;
  localparam int HOLD_CYCLES = 90;
  localparam int WIDTH_CAPS [12] = '{1, 2, 3, 4, 5, 6, 7, 9, 10, 14, 28, 32};

  logic clk = 1'b0;
  logic rst;

  bit quiet    = 1'b0;
  bit no_gaps  = 1'b0;
  bit hold_req = 1'b0;
  int items_sent;
  int stuck_cycles;
  int mismatches;
  int words_due;

  s16p_in_if  din ();
  s16p_out_if dout ();

  simple16_integer_packer_core dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din),
    .dout (dout)
  );

  s16p_checker chk (
    .clk        (clk),
    .rst        (rst),
    .din        (din),
    .dout       (dout),
    .mismatches (mismatches),
    .words_due  (words_due)
  );

  always #6 clk = ~clk;

  // Offers one integer request, with an optional idle burst ahead of it
  task automatic send_value(input logic [VALUE_W-1:0] v, input logic l);
    int gap;
    gap = 0;
    if (!quiet && !no_gaps && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 14);
    if (gap > 0) begin
      din.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    din.valid <= 1'b1;
    din.value <= v;
    din.last  <= l;
    do @(posedge clk); while (!din.ready);
    items_sent++;
  endtask

  // Mostly values near the array's width cap, sometimes any width
  function automatic logic [VALUE_W-1:0] rand_value(int cap);
    int bits;
    bits = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32) : $urandom_range(cap / 2, cap);
    return (bits == 0) ? '0 : ($urandom >> (32 - bits));
  endfunction

  initial begin
    int cap;
    int len;
    rst       <= 1'b1;
    din.valid <= 1'b0;
    din.value <= '0;
    din.last  <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: lone extremes, oversized values, partial groups, exact fits
    send_value(32'd0, 1'b1);
    send_value(32'hFFFF_FFFF, 1'b1);
    send_value(32'h0FFF_FFFF, 1'b1);
    send_value(32'h1000_0000, 1'b1);
    send_value(32'd16383, 1'b0);
    send_value(32'd16384, 1'b1);
    send_value(32'd3, 1'b0);
    send_value(32'd1, 1'b0);
    send_value(32'd1, 1'b1);
    send_value(32'd1023, 1'b0);
    send_value(32'd511, 1'b0);
    send_value(32'd511, 1'b1);
    send_value(32'hFFFF_FFFF, 1'b0);
    send_value(32'd1, 1'b1);
    send_value(32'd15, 1'b0);
    send_value(32'h8000_0001, 1'b0);
    send_value(32'd7, 1'b1);

    // long output hold-off while integers keep coming: buffer fills and input stalls
    items_sent = 0;
    hold_req   = 1'b1;
    no_gaps    = 1'b1;
    for (int k = 0; k < 70; k++) send_value(rand_value(2), k == 69);
    no_gaps = 1'b0;

    while (items_sent < 270) begin
      quiet = (items_sent >= 220);
      cap   = WIDTH_CAPS[$urandom_range(0, 11)];
      len   = ($urandom_range(0, 5) == 0) ? $urandom_range(29, 60) : $urandom_range(1, 28);
      for (int k = 0; k < len; k++) send_value(rand_value(cap), k == len - 1);
    end
    din.valid <= 1'b0;

    // let the checker take the final request before looking at its backlog
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && words_due == 0) begin
      $display("** simple16_integer_packer_core: PASSED **");
    end else begin
      $display("** simple16_integer_packer_core: FAILED **");
    end
    $finish;
  end

  // Output side: random ready bursts, one long hold-off on request, none when quiet
  initial begin
    dout.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req) begin
        dout.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        dout.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        dout.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (din.valid && din.ready) || (dout.valid && dout.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("** simple16_integer_packer_core: FAILED **");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

endmodule

// ----- simple16_integer_packer_core.f -----
rtl/s16p_pkg.sv
rtl/s16p_in_if.sv
rtl/s16p_out_if.sv
rtl/simple16_integer_packer_core.sv
sim/s16p_checker.sv
sim/tb_simple16_integer_packer_core.sv
